// ===== src/cpq_pkg.sv =====
// Shared widths, codes and types of the categorical pmf/cdf/quantile core.
package cpq_pkg;

    localparam int MAX_CATEGORIES_DEF = 16;
    localparam int FRAC_BITS          = 16;

    localparam int WEIGHT_W   = 16;
    localparam int VALUE_W    = FRAC_BITS + 1;
    localparam int STATUS_W   = 2;
    localparam int ACTION_W   = 2;
    localparam int SLOT_W     = 4;
    localparam int CAT_W      = 8;
    localparam int PROB_W     = 18;
    localparam int NCAT_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD     = 2'd0,
        ACT_DENSITY  = 2'd1,
        ACT_CDF      = 2'd2,
        ACT_QUANTILE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_TABLE = 2'd1,
        STAT_BAD_PROB  = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CATEGORIES = 2'd0,
        CFG_UPPER_TAIL     = 2'd1
    } cfg_idx_t;

endpackage

// ===== src/categorical_pmf_cdf_quantile_core.sv =====
// Categorical distribution core: weight table, density, cdf and quantile queries.
//
//  port group      dir  fields (low bit first)
//  s_axis_*        in   tuser: action; tdata: slot, weight, category, probability
//  m_axis_*        out  tdata: value, status
//  cfg_*           in   index 0 num_categories, index 1 upper_tail
//
//  A load writes its weight into the table when accepted and gives no output. Density
//  and cdf run accept, walk the table, decide, the serial divider (load, one quotient bit
//  at a time, done), then out. A quantile walks the table a second time instead of dividing;
//  a result settled in the decide step skips both. The table has a single read port.
//  Reset clears the table's valid bits at once; no clearing pass.
//  A finished result waits in the output register while the next item enters.
module categorical_pmf_cdf_quantile_core #(
    parameter int MAX_CATEGORIES = cpq_pkg::MAX_CATEGORIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // slot[3:0], weight[19:4], category[27:20], probability[45:28], zero pad
    input  logic [cpq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [cpq_pkg::ACTION_W-1:0]   s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // value[16:0], status[18:17], zero pad
    output logic [cpq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cpq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cpq_pkg::*;

    localparam int AW     = (MAX_CATEGORIES > 2) ? $clog2(MAX_CATEGORIES) : 1;
    localparam int CW     = $clog2(MAX_CATEGORIES + 1);
    localparam int KW     = ((CW > NCAT_W) ? CW : NCAT_W) + 1;
    localparam int CMPW   = ((CW > CAT_W) ? CW : CAT_W) + 1;
    localparam int SUM_W  = WEIGHT_W - 1 + AW;
    localparam int PROD_W = FRAC_BITS + SUM_W;
    localparam int P_W    = PROB_W + 1;
    localparam int SLOTCW = SLOT_W + AW + 1;
    localparam int OFS_WEIGHT = SLOT_W;
    localparam int OFS_CAT    = OFS_WEIGHT + WEIGHT_W;
    localparam int OFS_PROB   = OFS_CAT + CAT_W;

    localparam logic [VALUE_W-1:0]    ONE_VAL = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [P_W-1:0] P_ONE   = {{(P_W - VALUE_W){1'b0}}, ONE_VAL};

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DECIDE,
        S_DIV,
        S_SCAN,
        S_OUT
    } state_t;

    state_t                  state_reg;
    action_t                 act_reg;
    logic [CAT_W-1:0]        cat_reg;
    logic signed [P_W-1:0]   p_reg;
    logic [CW-1:0]           k_reg;
    logic [CW-1:0]           j_reg;
    logic                    rdv_reg;
    logic [CW-1:0]           didx_reg;
    logic [SUM_W-1:0]        total_reg;
    logic [SUM_W-1:0]        pre_reg;
    logic [WEIGHT_W-2:0]     wcat_reg;
    logic                    neg_reg;
    logic [PROD_W-1:0]       target_reg;
    logic [SUM_W-1:0]        div_num_reg;
    logic                    div_start_reg;
    logic [VALUE_W-1:0]      res_value_reg;
    status_t                 res_status_reg;
    logic                    m_tvalid_reg;
    logic [VALUE_W-1:0]      m_value_reg;
    status_t                 m_status_reg;
    logic [NCAT_W-1:0]       cfg_ncat_reg;
    logic                    cfg_upper_reg;

    action_t                 in_action;
    logic [SLOT_W-1:0]       in_slot;
    logic [WEIGHT_W-1:0]     in_weight;
    logic [CAT_W-1:0]        in_cat;
    logic [PROB_W-1:0]       in_prob;
    logic signed [P_W-1:0]   p_in;
    logic signed [P_W-1:0]   p_calc;
    logic [CW-1:0]           k_calc;
    logic                    s_fire;
    logic                    tbl_wr_en;
    logic                    tbl_rd_en;
    logic [WEIGHT_W-1:0]     tbl_rd_data;
    logic                    w_neg;
    logic [WEIGHT_W-2:0]     w_mag;
    logic [SUM_W-1:0]        scan_sum;
    logic                    hit;
    logic                    tbl_ok;
    logic                    div_done;
    logic [VALUE_W-1:0]      div_quot;
    logic                    out_load;
    logic [VALUE_W-1:0]      dec_value;
    status_t                 dec_status;
    logic                    dec_div;
    logic [SUM_W-1:0]        dec_num;
    logic                    dec_scan;

    assign in_action = action_t'(s_axis_tuser);
    assign in_slot   = s_axis_tdata[SLOT_W-1:0];
    assign in_weight = s_axis_tdata[OFS_WEIGHT +: WEIGHT_W];
    assign in_cat    = s_axis_tdata[OFS_CAT +: CAT_W];
    assign in_prob   = s_axis_tdata[OFS_PROB +: PROB_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign p_in   = {in_prob[PROB_W-1], in_prob};
    assign p_calc = cfg_upper_reg ? (P_ONE - p_in) : p_in;

    always_comb begin
        if (cfg_ncat_reg < NCAT_W'(2)) begin
            k_calc = CW'(2);
        end else if (KW'(cfg_ncat_reg) > KW'(MAX_CATEGORIES)) begin
            k_calc = CW'(MAX_CATEGORIES);
        end else begin
            k_calc = CW'(cfg_ncat_reg);
        end
    end

    assign tbl_wr_en = s_fire && (in_action == ACT_LOAD)
                       && (SLOTCW'(in_slot) < SLOTCW'(MAX_CATEGORIES));
    assign tbl_rd_en = ((state_reg == S_WALK) || (state_reg == S_SCAN)) && (j_reg < k_reg);

    cpq_table #(
        .DEPTH (MAX_CATEGORIES),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (tbl_wr_en),
        .wr_addr (AW'(in_slot)),
        .wr_data (in_weight),
        .rd_en   (tbl_rd_en),
        .rd_addr (j_reg[AW-1:0]),
        .rd_data (tbl_rd_data)
    );

    cpq_div #(
        .DEN_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .numer   (div_num_reg),
        .denom   (total_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign w_neg    = tbl_rd_data[WEIGHT_W-1];
    assign w_mag    = tbl_rd_data[WEIGHT_W-2:0];
    assign scan_sum = pre_reg + SUM_W'(w_mag);
    assign hit      = ({scan_sum, {FRAC_BITS{1'b0}}} >= target_reg);
    assign tbl_ok   = !neg_reg && (total_reg != '0);
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_axis_tready);

    always_comb begin
        dec_value  = '0;
        dec_status = STAT_OK;
        dec_div    = 1'b0;
        dec_num    = pre_reg;
        dec_scan   = 1'b0;
        case (act_reg)
            ACT_DENSITY: begin
                if ((cat_reg == '0) || (CMPW'(cat_reg) > CMPW'(k_reg))) begin
                    dec_status = STAT_OK;
                end else if (!tbl_ok) begin
                    dec_status = STAT_BAD_TABLE;
                end else begin
                    dec_num = SUM_W'(wcat_reg);
                    dec_div = 1'b1;
                end
            end
            ACT_CDF: begin
                if (cat_reg == '0) begin
                    dec_value = cfg_upper_reg ? ONE_VAL : '0;
                end else if (CMPW'(cat_reg) >= CMPW'(k_reg)) begin
                    dec_value = cfg_upper_reg ? '0 : ONE_VAL;
                end else if (!tbl_ok) begin
                    dec_status = STAT_BAD_TABLE;
                end else begin
                    dec_div = 1'b1;
                end
            end
            ACT_QUANTILE: begin
                if (!tbl_ok) begin
                    dec_status = STAT_BAD_TABLE;
                end else if (p_reg[P_W-1] || (p_reg > P_ONE)) begin
                    dec_status = STAT_BAD_PROB;
                end else if (p_reg == '0) begin
                    dec_value = VALUE_W'(1);
                end else if (p_reg == P_ONE) begin
                    dec_value = VALUE_W'(k_reg);
                end else begin
                    dec_scan = 1'b1;
                end
            end
            ACT_LOAD: begin
                dec_status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            div_start_reg <= 1'b0;
            rdv_reg       <= 1'b0;
            j_reg         <= '0;
            cfg_ncat_reg  <= NCAT_W'(2);
            cfg_upper_reg <= 1'b0;
        end else begin
            div_start_reg <= (state_reg == S_DECIDE) && dec_div;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NUM_CATEGORIES: cfg_ncat_reg  <= cfg_data;
                    CFG_UPPER_TAIL:     cfg_upper_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire && (in_action != ACT_LOAD)) begin
                        act_reg   <= in_action;
                        cat_reg   <= in_cat;
                        p_reg     <= p_calc;
                        k_reg     <= k_calc;
                        j_reg     <= '0;
                        rdv_reg   <= 1'b0;
                        total_reg <= '0;
                        pre_reg   <= '0;
                        wcat_reg  <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (tbl_rd_en) begin
                        j_reg <= j_reg + CW'(1);
                    end
                    rdv_reg  <= tbl_rd_en;
                    didx_reg <= j_reg;
                    if (rdv_reg) begin
                        if (w_neg) begin
                            neg_reg <= 1'b1;
                        end else begin
                            total_reg <= total_reg + SUM_W'(w_mag);
                        end
                        if (CMPW'(didx_reg) < CMPW'(cat_reg)) begin
                            pre_reg <= pre_reg + SUM_W'(w_mag);
                        end
                        if (CMPW'(didx_reg) + CMPW'(1) == CMPW'(cat_reg)) begin
                            wcat_reg <= w_mag;
                        end
                    end
                    if (!tbl_rd_en && !rdv_reg) begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    res_value_reg  <= dec_value;
                    res_status_reg <= dec_status;
                    div_num_reg    <= dec_num;
                    if (dec_scan) begin
                        target_reg <= PROD_W'(p_reg[FRAC_BITS-1:0])
                                      * PROD_W'(total_reg);
                        j_reg      <= '0;
                        rdv_reg    <= 1'b0;
                        pre_reg    <= '0;
                    end
                    state_reg <= dec_div ? S_DIV : (dec_scan ? S_SCAN : S_OUT);
                end
                S_DIV: begin
                    if (div_done) begin
                        res_value_reg  <= ((act_reg == ACT_CDF) && cfg_upper_reg)
                                          ? (ONE_VAL - div_quot) : div_quot;
                        res_status_reg <= STAT_OK;
                        state_reg      <= S_OUT;
                    end
                end
                S_SCAN: begin
                    if (tbl_rd_en) begin
                        j_reg <= j_reg + CW'(1);
                    end
                    rdv_reg  <= tbl_rd_en;
                    didx_reg <= j_reg;
                    if (rdv_reg) begin
                        pre_reg <= scan_sum;
                        if (hit || (didx_reg == k_reg - CW'(1))) begin
                            res_value_reg  <= VALUE_W'(didx_reg) + VALUE_W'(1);
                            res_status_reg <= STAT_OK;
                            state_reg      <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_value_reg  <= res_value_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - VALUE_W - STATUS_W){1'b0}}, m_status_reg, m_value_reg};

`ifndef SYNTHESIS
    a_err_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg != STAT_OK)) |-> (m_value_reg == '0))
        else $error("nonzero value with error status");

    a_value_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_value_reg <= ONE_VAL))
        else $error("result value above one");

    a_div_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (in_action != ACT_LOAD)) |=> !s_axis_tready)
        else $error("input still open after a query item");
`endif

endmodule

// ===== src/cpq_table.sv =====
// Weight table: synchronous memory with one write and one registered read port.
module cpq_table #(
    parameter int DEPTH = cpq_pkg::MAX_CATEGORIES_DEF,
    parameter int AW    = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [cpq_pkg::WEIGHT_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [cpq_pkg::WEIGHT_W-1:0] rd_data
);
    import cpq_pkg::*;

    logic [WEIGHT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [WEIGHT_W-1:0] rd_word_reg;
    logic                rd_ok_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_ok_reg ? rd_word_reg : '0;

endmodule

// ===== src/cpq_div.sv =====
// Serial restoring divider: rounded share num * 2^FRAC_BITS / den, one bit a cycle.
module cpq_div #(
    parameter int DEN_W = 19
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [DEN_W-1:0]            numer,
    input  logic [DEN_W-1:0]            denom,
    output logic                        done,
    output logic [cpq_pkg::VALUE_W-1:0] quot
);
    import cpq_pkg::*;

    localparam int NUM_W = DEN_W + FRAC_BITS + 1;
    localparam int SH_W  = DEN_W + FRAC_BITS;
    localparam int CNT_W = $clog2(VALUE_W + 1);

    logic [NUM_W-1:0]   rem_reg;
    logic [SH_W-1:0]    dsh_reg;
    logic [VALUE_W-1:0] q_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               ge;

    assign ge = (NUM_W'(dsh_reg) <= rem_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(1));
            if (start) begin
                rem_reg  <= NUM_W'({numer, {FRAC_BITS{1'b0}}}) + NUM_W'(denom >> 1);
                dsh_reg  <= {denom, {FRAC_BITS{1'b0}}};
                q_reg    <= '0;
                cnt_reg  <= CNT_W'(VALUE_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (ge) begin
                    rem_reg <= rem_reg - NUM_W'(dsh_reg);
                end
                q_reg   <= {q_reg[VALUE_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
